@@ rtl/mst_pkg.sv @@
// Shared types and constants for the MIPS subset instruction step block.
// No dependencies; imported by every other module of the block except mst_ram.
`default_nettype none

package mst_pkg;

  localparam int NumRegs  = 32;
  localparam int RegAddrW = $clog2(NumRegs);
  localparam int DataW    = 32;
  localparam int LimitW   = 17;
  localparam logic [LimitW-1:0] LimitReset = 17'd1024;

  typedef enum logic [2:0] {
    FN_ADD  = 3'd0,
    FN_SUB  = 3'd1,
    FN_ADDI = 3'd2,
    FN_LW   = 3'd3,
    FN_SW   = 3'd4,
    FN_BEQ  = 3'd5,
    FN_J    = 3'd6,
    FN_UNK  = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_JUMP    = 2'd2,
    ST_PAST    = 2'd3
  } status_t;

  localparam logic [5:0] OpAddi  = 6'b001000;
  localparam logic [5:0] OpLw    = 6'b100011;
  localparam logic [5:0] OpSw    = 6'b101011;
  localparam logic [5:0] OpBeq   = 6'b000100;
  localparam logic [5:0] OpJ     = 6'b000010;
  localparam logic [5:0] FunctAdd = 6'b100000;
  localparam logic [5:0] FunctSub = 6'b100010;

  localparam logic [1:0] AluOpMem = 2'd0;
  localparam logic [1:0] AluOpBeq = 2'd1;
  localparam logic [1:0] AluOpR   = 2'd2;

  typedef struct packed {
    func_t                func;
    logic [RegAddrW-1:0]  src_reg;
    logic [RegAddrW-1:0]  second_reg;
    logic [RegAddrW-1:0]  dest_reg;
    logic [15:0]          immediate;
  } instr_t;

  typedef struct packed {
    logic [DataW-1:0] machine_word;
    logic [1:0]       alu_op;
    logic             reg_dst;
    logic             alu_src;
    logic             mem_to_reg;
    logic             reg_write;
    logic             mem_read;
    logic             mem_write;
    logic             branch;
    logic [DataW-1:0] write_value;
    logic [DataW-1:0] next_pc;
    status_t          status;
  } res_t;

  typedef struct packed {
    logic                en;
    logic [RegAddrW-1:0] addr;
    logic [DataW-1:0]    data;
  } wr_t;

endpackage

`default_nettype wire

@@ rtl/mst_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module mst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/mst_regfile.sv @@
// Register file: two RAM copies for the rs/rt reads, per-entry valid bits
// for reset-to-zero, and a bypass for a write landing on the read edge.
// Depends on mst_pkg and mst_ram.
`default_nettype none

module mst_regfile
  import mst_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                rd_en,
  input  wire logic [RegAddrW-1:0] rs_addr,
  input  wire logic [RegAddrW-1:0] rt_addr,
  input  wire wr_t                 wr,
  output      logic [DataW-1:0]    rs_data,
  output      logic [DataW-1:0]    rt_data
);

  logic [DataW-1:0]    ram_a;
  logic [DataW-1:0]    ram_b;
  logic [NumRegs-1:0]  vld;
  logic [RegAddrW-1:0] rs_q;
  logic [RegAddrW-1:0] rt_q;
  logic                vld_a;
  logic                vld_b;
  wr_t                 byp;

  mst_ram #(.WIDTH(DataW), .DEPTH(NumRegs)) u_ram_a (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd_en),
    .raddr (rs_addr),
    .rdata (ram_a)
  );

  mst_ram #(.WIDTH(DataW), .DEPTH(NumRegs)) u_ram_b (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd_en),
    .raddr (rt_addr),
    .rdata (ram_b)
  );

  // valid bits sampled with the read so they match the RAM data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      byp   <= '0;
      vld_a <= 1'b0;
      vld_b <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        byp   <= wr;
        vld_a <= vld[rs_addr];
        vld_b <= vld[rt_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rs_q <= rs_addr;
      rt_q <= rt_addr;
    end
  end

  always_comb begin
    if (byp.en && byp.addr == rs_q) begin
      rs_data = byp.data;
    end else if (vld_a) begin
      rs_data = ram_a;
    end else begin
      rs_data = '0;
    end
    if (byp.en && byp.addr == rt_q) begin
      rt_data = byp.data;
    end else if (vld_b) begin
      rt_data = ram_b;
    end else begin
      rt_data = '0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/mst_exec.sv @@
// Decode and execute: encoding, control values, ALU result, next PC,
// status and register write request for one instruction.
// Depends on mst_pkg.
`default_nettype none

module mst_exec
  import mst_pkg::*;
(
  input  wire instr_t            instr,
  input  wire logic [DataW-1:0]  pc,
  input  wire logic [LimitW-1:0] limit,
  input  wire logic [DataW-1:0]  a,
  input  wire logic [DataW-1:0]  b,
  output      res_t              res,
  output      wr_t               wr
);

  logic [DataW-1:0]    simm;
  logic [DataW-1:0]    pc4;
  logic                past;
  logic signed [33:0]  jtgt;
  logic [34:0]         jend;
  logic                jok;
  logic                do_write;
  logic [RegAddrW-1:0] wreg;

  assign simm = {{16{instr.immediate[15]}}, instr.immediate};
  assign pc4  = pc + 32'd4;
  assign past = ({1'b0, pc} + 33'd4) > {16'b0, limit};
  assign jtgt = $signed({2'b00, pc}) + $signed({simm[31:0], 2'b00});
  assign jend = {jtgt[33], jtgt} + 35'd4;
  assign jok  = !jtgt[33] && (jend <= {18'b0, limit});

  always_comb begin
    res          = '0;
    res.next_pc  = pc;
    res.status   = ST_OK;
    do_write     = 1'b0;
    wreg         = instr.dest_reg;
    case (instr.func)
      FN_ADD, FN_SUB: begin
        res.machine_word = {6'b0, instr.src_reg, instr.second_reg, instr.dest_reg, 5'b0,
                            (instr.func == FN_ADD) ? FunctAdd : FunctSub};
        res.alu_op      = AluOpR;
        res.reg_dst     = 1'b1;
        res.reg_write   = 1'b1;
        res.write_value = (instr.func == FN_ADD) ? a + b : a - b;
        do_write        = 1'b1;
        res.next_pc     = pc4;
      end
      FN_ADDI: begin
        res.machine_word = {OpAddi, instr.src_reg, instr.second_reg, instr.immediate};
        res.alu_op      = AluOpR;
        res.alu_src     = 1'b1;
        res.reg_write   = 1'b1;
        res.write_value = a + simm;
        do_write        = 1'b1;
        wreg            = instr.second_reg;
        res.next_pc     = pc4;
      end
      FN_LW: begin
        res.machine_word = {OpLw, instr.src_reg, instr.second_reg, instr.immediate};
        res.alu_src    = 1'b1;
        res.mem_to_reg = 1'b1;
        res.reg_write  = 1'b1;
        res.mem_read   = 1'b1;
        res.next_pc    = pc4;
      end
      FN_SW: begin
        res.machine_word = {OpSw, instr.src_reg, instr.second_reg, instr.immediate};
        res.alu_src   = 1'b1;
        res.mem_write = 1'b1;
        res.next_pc   = pc4;
      end
      FN_BEQ: begin
        res.machine_word = {OpBeq, instr.src_reg, instr.second_reg, instr.immediate};
        res.alu_op  = AluOpBeq;
        res.branch  = 1'b1;
        res.next_pc = (a == b) ? pc4 + {simm[29:0], 2'b00} : pc4;
      end
      FN_J: begin
        res.machine_word = {OpJ, simm[25:0]};
        if (jok) begin
          res.next_pc = jtgt[31:0];
        end else begin
          res.status = ST_JUMP;
        end
      end
      default: begin
        res.status = ST_UNKNOWN;
      end
    endcase
    if (past) begin
      res.status      = ST_PAST;
      res.next_pc     = pc;
      res.write_value = '0;
      do_write        = 1'b0;
    end
  end

  assign wr.en   = do_write && (wreg != '0);
  assign wr.addr = wreg;
  assign wr.data = res.write_value;

endmodule

`default_nettype wire

@@ rtl/mips_subset_instruction_step.sv @@
// Top level of the MIPS subset instruction step block.
// Depends on mst_pkg, mst_regfile (with mst_ram) and mst_exec.
//
// One decoded instruction enters per beat on the s_ channel; one result
// beat leaves on the m_ channel for every instruction, in order.
// The memory_limit register is written through cfg_valid/cfg_ready/cfg_data,
// always ready; write it only while the block is idle.
// Stages: the register file read (registered RAM output) is the first;
// execute and write-back happen in the second, together with the load of
// the output register.
// Throughput: one instruction per cycle while m_tready is high. A write
// landing on the same edge as the next read is forwarded from a bypass register.
// Reset: register file reads as zero (per-entry valid bits cleared),
// PC cleared, memory_limit set to 1024, both pipeline stages emptied.
// When m_tready is low the result holds, the execute stage holds its item
// and RAM data, and s_tready drops once both are full.
`default_nettype none

module mips_subset_instruction_step
  import mst_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  output      logic          cfg_ready,
  input  wire logic [16:0]   cfg_data,   // memory_limit
  input  wire logic          s_tvalid,
  output      logic          s_tready,
  // func[2:0], src_reg[7:3], second_reg[12:8], dest_reg[17:13], immediate[33:18]
  input  wire logic [39:0]   s_tdata,
  output      logic          m_tvalid,
  input  wire logic          m_tready,
  // machine_word[31:0], alu_op[33:32], reg_dst[34], alu_src[35], mem_to_reg[36],
  // reg_write[37], mem_read[38], mem_write[39], branch[40], write_value[72:41],
  // next_pc[104:73], status[106:105]
  output      logic [111:0]  m_tdata
);

  logic [LimitW-1:0] limit;
  logic [DataW-1:0]  pc;
  logic              s1_valid;
  instr_t            s1_instr;
  instr_t            in_instr;
  logic              s1_fire;
  logic              in_fire;
  logic [DataW-1:0]  rs_data;
  logic [DataW-1:0]  rt_data;
  res_t              res;
  res_t              out_res;
  wr_t               ex_wr;
  wr_t               rf_wr;

  assign in_instr.func       = func_t'(s_tdata[2:0]);
  assign in_instr.src_reg    = s_tdata[7:3];
  assign in_instr.second_reg = s_tdata[12:8];
  assign in_instr.dest_reg   = s_tdata[17:13];
  assign in_instr.immediate  = s_tdata[33:18];

  assign cfg_ready = 1'b1;
  assign s1_fire   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready  = !s1_valid || s1_fire;
  assign in_fire   = s_tvalid && s_tready;

  assign rf_wr.en   = ex_wr.en && s1_fire;
  assign rf_wr.addr = ex_wr.addr;
  assign rf_wr.data = ex_wr.data;

  mst_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rs_addr (in_instr.src_reg),
    .rt_addr (in_instr.second_reg),
    .wr      (rf_wr),
    .rs_data (rs_data),
    .rt_data (rt_data)
  );

  mst_exec u_exec (
    .instr (s1_instr),
    .pc    (pc),
    .limit (limit),
    .a     (rs_data),
    .b     (rt_data),
    .res   (res),
    .wr    (ex_wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      limit    <= LimitReset;
      pc       <= '0;
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit <= cfg_data;
      end
      if (s1_fire) begin
        pc <= res.next_pc;
      end
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_instr <= in_instr;
    end
    if (s1_fire) begin
      out_res <= res;
    end
  end

  assign m_tdata = {5'b0, out_res.status, out_res.next_pc, out_res.write_value,
                    out_res.branch, out_res.mem_write, out_res.mem_read,
                    out_res.reg_write, out_res.mem_to_reg, out_res.alu_src,
                    out_res.reg_dst, out_res.alu_op, out_res.machine_word};

endmodule

`default_nettype wire

@@ tb/mst_step_check.sv @@
// Checker for the MIPS subset instruction step block: watches the limit write,
// instruction and result channels, predicts every result and compares it.
// Depends on mst_pkg for the opcode, function and status encodings.
`timescale 1ns / 100ps

module mst_step_check
  import mst_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [16:0]  cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [39:0]  s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [111:0] m_tdata,
  output int           mismatches,
  output int           outstanding,
  output int           checked,
  output logic [31:0]  pc_now
);

  logic [DataW-1:0]  gpr [NumRegs];
  logic [DataW-1:0]  pc;
  logic [LimitW-1:0] mem_limit;
  res_t              due_results [$];

  // Executes one instruction against the shadow state and returns its result.
  function automatic res_t step_instr(instr_t ins);
    res_t        r;
    logic [31:0] a, b, simm, npc, wval;
    logic [4:0]  wreg;
    logic        wr, past;
    longint      tgt;
    r    = '0;
    a    = gpr[ins.src_reg];
    b    = gpr[ins.second_reg];
    simm = {{16{ins.immediate[15]}}, ins.immediate};
    npc  = pc;
    wval = '0;
    wreg = '0;
    wr   = 1'b0;
    r.status = ST_OK;
    past = ({1'b0, pc} + 33'd4) > {16'd0, mem_limit};
    case (ins.func)
      FN_ADD, FN_SUB: begin
        r.machine_word = {6'd0, ins.src_reg, ins.second_reg, ins.dest_reg, 5'd0,
                          (ins.func == FN_ADD) ? FunctAdd : FunctSub};
        r.alu_op    = AluOpR;
        r.reg_dst   = 1'b1;
        r.reg_write = 1'b1;
        wval = (ins.func == FN_ADD) ? a + b : a - b;
        wreg = ins.dest_reg;
        wr   = 1'b1;
        npc  = pc + 32'd4;
      end
      FN_ADDI: begin
        r.machine_word = {OpAddi, ins.src_reg, ins.second_reg, ins.immediate};
        r.alu_op    = AluOpR;
        r.alu_src   = 1'b1;
        r.reg_write = 1'b1;
        wval = a + simm;
        wreg = ins.second_reg;
        wr   = 1'b1;
        npc  = pc + 32'd4;
      end
      FN_LW: begin
        r.machine_word = {OpLw, ins.src_reg, ins.second_reg, ins.immediate};
        r.alu_op     = AluOpMem;
        r.alu_src    = 1'b1;
        r.mem_to_reg = 1'b1;
        r.reg_write  = 1'b1;
        r.mem_read   = 1'b1;
        npc = pc + 32'd4;
      end
      FN_SW: begin
        r.machine_word = {OpSw, ins.src_reg, ins.second_reg, ins.immediate};
        r.alu_op    = AluOpMem;
        r.alu_src   = 1'b1;
        r.mem_write = 1'b1;
        npc = pc + 32'd4;
      end
      FN_BEQ: begin
        r.machine_word = {OpBeq, ins.src_reg, ins.second_reg, ins.immediate};
        r.alu_op = AluOpBeq;
        r.branch = 1'b1;
        npc = (a == b) ? pc + 32'd4 + (simm << 2) : pc + 32'd4;
      end
      FN_J: begin
        r.machine_word = {OpJ, simm[25:0]};
        r.alu_op = AluOpMem;
        tgt = longint'(pc) + longint'($signed(ins.immediate)) * 4;
        if (tgt >= 0 && tgt + 4 <= longint'(mem_limit)) npc = tgt[31:0];
        else r.status = ST_JUMP;
      end
      default: r.status = ST_UNKNOWN;
    endcase
    if (past) begin
      r.status = ST_PAST;
      npc  = pc;
      wval = '0;
      wr   = 1'b0;
    end
    if (wr && wreg != 0) gpr[wreg] = wval;
    pc = npc;
    r.write_value = wval;
    r.next_pc     = npc;
    return r;
  endfunction

  task automatic check_field(string fname, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in result %0d, %s: expected %h, got %h",
                 checked, fname, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    instr_t ins;
    res_t   want, got;
    if (rst) begin
      foreach (gpr[k]) gpr[k] = '0;
      pc          = '0;
      mem_limit   = LimitReset;
      mismatches  = 0;
      checked     = 0;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) mem_limit = cfg_data;
      if (m_tvalid && m_tready) begin
        got.machine_word = m_tdata[31:0];
        got.alu_op       = m_tdata[33:32];
        got.reg_dst      = m_tdata[34];
        got.alu_src      = m_tdata[35];
        got.mem_to_reg   = m_tdata[36];
        got.reg_write    = m_tdata[37];
        got.mem_read     = m_tdata[38];
        got.mem_write    = m_tdata[39];
        got.branch       = m_tdata[40];
        got.write_value  = m_tdata[72:41];
        got.next_pc      = m_tdata[104:73];
        got.status       = status_t'(m_tdata[106:105]);
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result beat %0d arrived with nothing due", checked);
        end else begin
          want = due_results.pop_front();
          check_field("machine_word", want.machine_word, got.machine_word);
          check_field("alu_op", want.alu_op, got.alu_op);
          check_field("reg_dst", want.reg_dst, got.reg_dst);
          check_field("alu_src", want.alu_src, got.alu_src);
          check_field("mem_to_reg", want.mem_to_reg, got.mem_to_reg);
          check_field("reg_write", want.reg_write, got.reg_write);
          check_field("mem_read", want.mem_read, got.mem_read);
          check_field("mem_write", want.mem_write, got.mem_write);
          check_field("branch", want.branch, got.branch);
          check_field("write_value", want.write_value, got.write_value);
          check_field("next_pc", want.next_pc, got.next_pc);
          check_field("status", want.status, got.status);
        end
        checked++;
      end
      if (s_tvalid && s_tready) begin
        ins.func       = func_t'(s_tdata[2:0]);
        ins.src_reg    = s_tdata[7:3];
        ins.second_reg = s_tdata[12:8];
        ins.dest_reg   = s_tdata[17:13];
        ins.immediate  = s_tdata[33:18];
        due_results.push_back(step_instr(ins));
      end
    end
    outstanding = due_results.size();
    pc_now      = pc;
  end

endmodule

@@ tb/tb_mips_subset_instruction_step.sv @@
// Testbench top for mips_subset_instruction_step: drives instructions and limit
// writes with random gaps and stalls; mst_step_check predicts and compares.
// Depends on mst_pkg, the block under test and tb/mst_step_check.sv.
`timescale 1ns / 100ps

module tb_mips_subset_instruction_step;
  import mst_pkg::*;

  localparam int WatchLimit = 2000;

  logic         clk, rst;
  logic         cfg_valid, cfg_ready;
  logic [16:0]  cfg_data;
  logic         s_tvalid, s_tready;
  logic [39:0]  s_tdata;
  logic         m_tvalid, m_tready;
  logic [111:0] m_tdata;

  int           mismatches, outstanding, checked;
  logic [31:0]  pc_now;

  logic [16:0]  limit_now;
  bit           gaps_on;
  int           sent, n_cfg, idle_cycles;
  int           func_seen [8];

  mips_subset_instruction_step uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  mst_step_check u_step_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked),
    .pc_now      (pc_now)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= !(gaps_on && $urandom_range(99) < 26);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= WatchLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  function automatic logic [15:0] word_ofs(int from_b, int to_b);
    int d;
    d = (to_b - from_b) / 4;
    return d[15:0];
  endfunction

  function automatic logic [4:0] pick_reg();
    return $urandom_range(1) ? 5'($urandom_range(7)) : 5'($urandom_range(31));
  endfunction

  function automatic logic [15:0] pick_imm();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // One instruction beat; valid stays up afterwards unless the next call idles.
  task automatic send(input func_t f, input logic [4:0] rs, input logic [4:0] rt,
                      input logic [4:0] rd, input logic [15:0] imm);
    while (gaps_on && $urandom_range(99) < 26) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata  = {6'd0, imm, rd, rt, rs, f};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    sent++;
    func_seen[f]++;
  endtask

  task automatic write_limit(input logic [16:0] v);
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_data  = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    limit_now = v;
    n_cfg++;
  endtask

  // Bring the PC back to 0, opening the limit first if the PC is stuck.
  task automatic retreat();
    if (int'(pc_now) + 4 > int'(limit_now) || limit_now < 16) write_limit(17'h1FFFF);
    send(FN_J, pick_reg(), pick_reg(), pick_reg(), word_ofs(int'(pc_now), 0));
  endtask

  task automatic rand_item();
    int          roll, lim, pc, tgt, fsel;
    logic [4:0]  rs, rt, rd;
    logic [15:0] imm;
    lim = int'(limit_now);
    pc  = int'(pc_now);
    rs  = pick_reg();
    rt  = pick_reg();
    rd  = pick_reg();
    imm = pick_imm();
    roll = $urandom_range(99);
    if (pc + 4 > lim) begin
      send(func_t'($urandom_range(7)), 5'($urandom_range(31)), 5'($urandom_range(31)),
           5'($urandom_range(31)), 16'($urandom_range(16'hFFFF)));
    end else if (pc + 16 > lim) begin
      tgt = (lim < 20) ? 0 : 4 * $urandom_range(0, (lim - 16) / 4);
      send(FN_J, rs, rt, rd, word_ofs(pc, tgt));
    end else if (roll < 15) send(FN_ADD, rs, rt, rd, imm);
    else if (roll < 27) send(FN_SUB, rs, rt, rd, imm);
    else if (roll < 42) send(FN_ADDI, rs, rt, rd, imm);
    else if (roll < 50) send(FN_LW, rs, rt, rd, imm);
    else if (roll < 58) send(FN_SW, rs, rt, rd, imm);
    else if (roll < 72) begin
      if ($urandom_range(1)) rt = rs;
      tgt = 4 * $urandom_range(0, (lim - 4) / 4);
      send(FN_BEQ, rs, rt, rd, word_ofs(pc + 4, tgt));
    end else if (roll < 80) begin
      tgt = 4 * $urandom_range(0, (lim - 4) / 4);
      send(FN_J, rs, rt, rd, word_ofs(pc, tgt));
    end else if (roll < 85) begin
      send(FN_J, rs, rt, rd, 16'($urandom_range(16'hFFFF)));
    end else if (roll < 87 && lim <= 131060) begin
      // taken branch that lands past the limit
      tgt = 4 * $urandom_range((lim + 3) / 4, 32766);
      send(FN_BEQ, rs, rs, rd, word_ofs(pc + 4, tgt));
    end else if (roll < 93) begin
      send(FN_UNK, 5'($urandom_range(31)), 5'($urandom_range(31)), 5'($urandom_range(31)),
           16'($urandom_range(16'hFFFF)));
    end else begin
      fsel = $urandom_range(6);
      if (fsel >= 5) fsel++;
      send(func_t'(3'(fsel)), rs, rt, rd, 16'($urandom_range(16'hFFFF)));
    end
  endtask

  task automatic run_phase(input logic [16:0] lim, input int n);
    int stuck;
    stuck = 0;
    retreat();
    write_limit(lim);
    repeat (n) begin
      if (int'(pc_now) + 4 > int'(limit_now)) stuck++;
      else stuck = 0;
      if (stuck > 4 && lim >= 16) begin
        retreat();
        write_limit(lim);
        stuck = 0;
      end
      rand_item();
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    gaps_on   = 1'b1;
    limit_now = LimitReset;
    sent      = 0;
    n_cfg     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, every operation, write to r0, branches and jumps
    send(FN_ADDI, 5'd0, 5'd1, 5'd0, 16'h7FFF);
    send(FN_ADDI, 5'd0, 5'd2, 5'd0, 16'h8000);
    send(FN_ADD, 5'd1, 5'd2, 5'd3, 16'h0000);
    send(FN_SUB, 5'd2, 5'd1, 5'd4, 16'hFFFF);
    send(FN_ADDI, 5'd1, 5'd0, 5'd9, 16'h0005);
    send(FN_ADD, 5'd1, 5'd1, 5'd31, 16'h0000);
    send(FN_SUB, 5'd31, 5'd31, 5'd31, 16'h0000);
    send(FN_SUB, 5'd4, 5'd1, 5'd0, 16'h1234);
    send(FN_ADD, 5'd31, 5'd31, 5'd0, 16'hFFFF);
    send(FN_LW, 5'd1, 5'd5, 5'd0, 16'hFFFF);
    send(FN_SW, 5'd31, 5'd31, 5'd31, 16'h7FFF);
    send(FN_BEQ, 5'd0, 5'd0, 5'd0, 16'h0002);
    send(FN_BEQ, 5'd1, 5'd2, 5'd0, 16'h0003);
    send(FN_BEQ, 5'd1, 5'd1, 5'd0, 16'hFFFF);
    send(FN_J, 5'd0, 5'd0, 5'd0, 16'h0003);
    send(FN_J, 5'd31, 5'd31, 5'd31, 16'h8000);
    send(FN_J, 5'd0, 5'd0, 5'd0, 16'h7FFF);
    send(FN_J, 5'd0, 5'd0, 5'd0, 16'hFFFE);
    send(FN_UNK, 5'd31, 5'd31, 5'd31, 16'hFFFF);
    send(FN_UNK, 5'd0, 5'd0, 5'd0, 16'h0000);

    run_phase(17'd1024, 150);
    run_phase(17'd65536, 170);
    gaps_on = 1'b0;
    run_phase(17'h1FFFF, 150);
    gaps_on = 1'b1;
    run_phase(17'd0, 20);
    run_phase(17'd4, 20);
    run_phase(17'd200, 150);
    run_phase(17'($urandom_range(4, 65536)), 150);
    run_phase(17'($urandom_range(4, 65536)), 150);
    run_phase(17'd1024, 130);

    // taken branch that wraps below zero; the PC stays past the limit after it
    retreat();
    send(FN_BEQ, 5'd0, 5'd0, 5'd0, 16'h8000);
    repeat (3) send(func_t'($urandom_range(7)), pick_reg(), pick_reg(), pick_reg(), pick_imm());

    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Ran %0d instructions: add %0d sub %0d addi %0d lw %0d sw %0d beq %0d j %0d unk %0d",
             sent, func_seen[FN_ADD], func_seen[FN_SUB], func_seen[FN_ADDI], func_seen[FN_LW],
             func_seen[FN_SW], func_seen[FN_BEQ], func_seen[FN_J], func_seen[FN_UNK]);
    $display("%0d memory limit writes, %0d results compared, %0d mismatches",
             n_cfg, checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
